>>> src/lla_pkg.sv
`timescale 1ns / 1ps
package lla_pkg;

  localparam int OP_W        = 2;
  localparam int COORD_W     = 6;
  localparam int GEN_W       = 32;
  localparam int MASK_W      = 9;
  localparam int GRID_SIZE_W = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int NBR_W       = 3;
  localparam int COUNT_W     = 4;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_BIRTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SURVIVE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT  = 2'd3;

  localparam logic [MASK_W-1:0]      BIRTH_RESET   = 9'd8;
  localparam logic [MASK_W-1:0]      SURVIVE_RESET = 9'd12;
  localparam logic [GRID_SIZE_W-1:0] SIZE_RESET    = 7'd64;

  // window control shared by every column cell
  typedef struct packed {
    logic clear;
    logic shift;
  } win_ctrl_t;

  typedef struct packed {
    logic             cell_out;
    logic [GEN_W-1:0] generation_now;
    logic             bad_coordinate;
  } result_t;

endpackage

>>> src/lla_in_if.sv
`timescale 1ns / 1ps
interface lla_in_if import lla_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic               cell_in;

  modport source (output valid, output operation, output column, output row,
                  output cell_in, input ready);
  modport sink (input valid, input operation, input column, input row,
                input cell_in, output ready);
endinterface

>>> src/lla_out_if.sv
`timescale 1ns / 1ps
interface lla_out_if import lla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cell_out;
  logic [GEN_W-1:0] generation_now;
  logic             bad_coordinate;

  modport source (output valid, output cell_out, output generation_now,
                  output bad_coordinate, input ready);
  modport sink (input valid, input cell_out, input generation_now,
                input bad_coordinate, output ready);
endinterface

>>> src/life_like_automaton_step.sv
`timescale 1ns / 1ps
// Write and unused-code words go to ST_DONE; reads pass through ST_READ first.
// Step: one grid row through the column cells per cycle, bounded by the single
// read port of the row memory.
// One word is worked on at a time; the next is taken while a result waits.
// Reset is synchronous: a clearing pass of all MAX_HEIGHT rows zeroes the grid
// before the first word is taken; registers return to 8, 12, 64, 64.
module life_like_automaton_step import lla_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  lla_in_if.sink                 in_item,
  lla_out_if.source              out_item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int RAW = $clog2(MAX_HEIGHT);
  localparam int CAW = $clog2(MAX_WIDTH);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > GRID_SIZE_W) ?
                       $clog2(MAX_WIDTH + 1) : GRID_SIZE_W;
  localparam int HW  = ($clog2(MAX_HEIGHT + 2) > GRID_SIZE_W) ?
                       $clog2(MAX_HEIGHT + 2) : GRID_SIZE_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_STEP  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [MASK_W-1:0]      birth_mask;
  logic [MASK_W-1:0]      survive_mask;
  logic [GRID_SIZE_W-1:0] grid_width;
  logic [GRID_SIZE_W-1:0] grid_height;
  logic [GEN_W-1:0]       generation;

  logic [MAX_WIDTH-1:0] grid_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rdata;

  logic [RAW-1:0] clr_k;
  logic [HW-1:0]  rd_k;
  logic           s1_valid;
  logic [HW-1:0]  s1_k;
  logic           s2_valid;
  logic [HW-1:0]  s2_k;
  logic [HW-1:0]  s2_prev;

  logic [CAW-1:0] rq_col;
  logic           rq_bad;
  result_t        res;
  result_t        out_res;
  logic           out_valid;

  logic [WW-1:0]  used_w;
  logic [HW-1:0]  used_h;
  logic [WW-1:0]  col_x;
  logic [HW-1:0]  row_x;
  logic           bad;
  logic           accept;

  logic           mem_we_row;
  logic           mem_we_bit;
  logic [RAW-1:0] mem_waddr;
  logic [RAW-1:0] mem_raddr;
  logic [MAX_WIDTH-1:0] mem_wrow;

  win_ctrl_t            win_ctrl;
  logic [MAX_WIDTH-1:0] row_in;
  logic [MAX_WIDTH-1:0] row_new;

  assign used_w = (WW'(grid_width) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(grid_width);
  assign used_h = (HW'(grid_height) > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(grid_height);
  assign col_x  = WW'(in_item.column);
  assign row_x  = HW'(in_item.row);
  assign bad    = (col_x >= used_w) || (row_x >= used_h);

  assign in_item.ready = (state == ST_IDLE);
  assign accept        = in_item.valid && in_item.ready;

  assign s2_prev = s2_k - HW'(1);

  // row memory: whole-row writes for clearing and steps, single bit for cell writes
  always_comb begin
    mem_we_row = (state == ST_CLEAR) || (s2_valid && (s2_k != '0));
    mem_we_bit = accept && (in_item.operation == OP_WRITE) && !bad;
    if (state == ST_CLEAR) begin
      mem_waddr = clr_k;
      mem_wrow  = '0;
    end else if (state == ST_STEP) begin
      mem_waddr = s2_prev[RAW-1:0];
      mem_wrow  = row_new;
    end else begin
      mem_waddr = row_x[RAW-1:0];
      mem_wrow  = row_new;
    end
    mem_raddr = (state == ST_STEP) ? rd_k[RAW-1:0] : row_x[RAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we_row) begin
      grid_mem[mem_waddr] <= mem_wrow;
    end else if (mem_we_bit) begin
      grid_mem[mem_waddr][col_x[CAW-1:0]] <= in_item.cell_in;
    end
    rdata <= grid_mem[mem_raddr];
  end

  // rows past the height in use enter the window as dead
  assign row_in         = (s1_k < used_h) ? rdata : '0;
  assign win_ctrl.clear = accept && (in_item.operation == OP_STEP);
  assign win_ctrl.shift = s1_valid;

  lla_row #(
    .WIDTH (MAX_WIDTH),
    .UW    (WW)
  ) u_row (
    .clk     (clk),
    .ctrl    (win_ctrl),
    .row_in  (row_in),
    .used_w  (used_w),
    .birth   (birth_mask),
    .survive (survive_mask),
    .row_out (row_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_k        <= '0;
      rd_k         <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      out_valid    <= 1'b0;
      generation   <= '0;
      birth_mask   <= BIRTH_RESET;
      survive_mask <= SURVIVE_RESET;
      grid_width   <= SIZE_RESET;
      grid_height  <= SIZE_RESET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_BIRTH:   birth_mask   <= cfg_data;
          REG_SURVIVE: survive_mask <= cfg_data;
          REG_WIDTH:   grid_width   <= cfg_data[GRID_SIZE_W-1:0];
          REG_HEIGHT:  grid_height  <= cfg_data[GRID_SIZE_W-1:0];
          default:     ;
        endcase
      end

      // row pipeline: issue read, shift into window, write back
      s1_valid <= (state == ST_STEP) && (rd_k <= used_h);
      s1_k     <= rd_k;
      s2_valid <= s1_valid;
      s2_k     <= s1_k;

      if ((state == ST_DONE) && (!out_valid || out_item.ready)) begin
        out_valid <= 1'b1;
      end else if (out_item.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_k <= clr_k + RAW'(1);
          if (clr_k == RAW'(MAX_HEIGHT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res.cell_out       <= 1'b0;
            res.generation_now <= generation;
            res.bad_coordinate <= (in_item.operation == OP_WRITE) && bad;
            unique case (in_item.operation)
              OP_WRITE: begin
                state <= ST_DONE;
              end
              OP_READ: begin
                rq_col <= col_x[CAW-1:0];
                rq_bad <= bad;
                state  <= ST_READ;
              end
              OP_STEP: begin
                rd_k  <= '0;
                state <= ST_STEP;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_READ: begin
          res.cell_out       <= rq_bad ? 1'b0 : rdata[rq_col];
          res.bad_coordinate <= rq_bad;
          state              <= ST_DONE;
        end
        ST_STEP: begin
          if (rd_k <= used_h) begin
            rd_k <= rd_k + HW'(1);
          end
          if (s2_valid && (s2_k == used_h)) begin
            generation         <= generation + GEN_W'(1);
            res.generation_now <= generation + GEN_W'(1);
            state              <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_item.ready) begin
            out_res <= res;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  assign out_item.valid          = out_valid;
  assign out_item.cell_out       = out_res.cell_out;
  assign out_item.generation_now = out_res.generation_now;
  assign out_item.bad_coordinate = out_res.bad_coordinate;

endmodule

>>> src/lla_cell.sv
`timescale 1ns / 1ps
module lla_cell import lla_pkg::*; (
  input  logic              clk,
  input  win_ctrl_t         ctrl,
  input  logic              bit_in,
  input  logic              in_use,
  input  logic [NBR_W-1:0]  left_bits,
  input  logic [NBR_W-1:0]  right_bits,
  input  logic [MASK_W-1:0] birth,
  input  logic [MASK_W-1:0] survive,
  output logic [NBR_W-1:0]  col_bits,
  output logic              new_bit
);

  logic               up;
  logic               mid;
  logic               dn;
  logic [COUNT_W-1:0] count;

  // three-row window of this column, advanced one row per shift
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      up  <= 1'b0;
      mid <= 1'b0;
      dn  <= 1'b0;
    end else if (ctrl.shift) begin
      up  <= mid;
      mid <= dn;
      dn  <= bit_in;
    end
  end

  // columns beyond the width in use look dead to their neighbours
  assign col_bits = in_use ? {up, mid, dn} : '0;

  assign count = COUNT_W'(left_bits[2]) + COUNT_W'(left_bits[1]) + COUNT_W'(left_bits[0])
               + COUNT_W'(right_bits[2]) + COUNT_W'(right_bits[1])
               + COUNT_W'(right_bits[0]) + COUNT_W'(up) + COUNT_W'(dn);

  always_comb begin
    if (!in_use) begin
      new_bit = mid;
    end else if (mid) begin
      new_bit = survive[count];
    end else begin
      new_bit = birth[count];
    end
  end

endmodule

>>> src/lla_row.sv
`timescale 1ns / 1ps
module lla_row import lla_pkg::*; #(
  parameter int WIDTH = 64,
  parameter int UW    = ($clog2(WIDTH + 1) > GRID_SIZE_W) ? $clog2(WIDTH + 1) : GRID_SIZE_W
) (
  input  logic              clk,
  input  win_ctrl_t         ctrl,
  input  logic [WIDTH-1:0]  row_in,
  input  logic [UW-1:0]     used_w,
  input  logic [MASK_W-1:0] birth,
  input  logic [MASK_W-1:0] survive,
  output logic [WIDTH-1:0]  row_out
);

  logic [NBR_W-1:0] col_bits [WIDTH];

  for (genvar x = 0; x < WIDTH; x++) begin : g_col
    logic [NBR_W-1:0] left_bits;
    logic [NBR_W-1:0] right_bits;

    if (x == 0) begin : g_left_edge
      assign left_bits = '0;
    end else begin : g_left
      assign left_bits = col_bits[x-1];
    end

    if (x == WIDTH - 1) begin : g_right_edge
      assign right_bits = '0;
    end else begin : g_right
      assign right_bits = col_bits[x+1];
    end

    lla_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .bit_in     (row_in[x]),
      .in_use     (used_w > UW'(x)),
      .left_bits  (left_bits),
      .right_bits (right_bits),
      .birth      (birth),
      .survive    (survive),
      .col_bits   (col_bits[x]),
      .new_bit    (row_out[x])
    );
  end

endmodule
